@@ rtl/core/otsu_histogram_threshold_top_assert.svh @@
// Assertion macros for the Otsu threshold block
`ifndef OTSU_HISTOGRAM_THRESHOLD_TOP_ASSERT_SVH
`define OTSU_HISTOGRAM_THRESHOLD_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define OTSU_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("otsu assertion failed");

// Next-cycle implication, checked outside reset
`define OTSU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("otsu assertion failed");

`endif

@@ rtl/core/otsu_pkg.sv @@
// Package: payload types and constants of the Otsu threshold block
`default_nettype none
package otsu_pkg;

  localparam int unsigned MaxPixels = 1048576;
  localparam int unsigned CntW      = 21;   // pixel count and bin width
  localparam int unsigned SumW      = 28;   // intensity sum width
  localparam int unsigned DiffW     = 49;   // N*s0 - S*c0
  localparam int unsigned DenW      = 42;   // c0*c1
  localparam int unsigned SqW       = 98;   // difference squared
  localparam int unsigned ProdW     = 140;  // squared difference times denominator
  localparam int unsigned MulBW     = 49;   // multiplier operand b

  localparam logic [7:0] NoSplitThr = 8'd128;

  typedef struct packed {
    logic [7:0] blue_or_gray;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       too_many_pixels;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage
`default_nettype wire

@@ rtl/core/otsu_mul.sv @@
// Shared shift-add multiplier, one bit of operand b per cycle
`default_nettype none
module otsu_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [otsu_pkg::ProdW-1:0]    a_i,
  input  wire logic [otsu_pkg::MulBW-1:0]    b_i,
  output otsu_pkg::mul_status_t              status_o,
  output logic [otsu_pkg::ProdW-1:0]         prod_o
);
  import otsu_pkg::*;

  logic             busy_q;
  logic [ProdW-1:0] a_q, acc_q;
  logic [MulBW-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[ProdW-2:0], 1'b0};
      b_q <= {1'b0, b_q[MulBW-1:1]};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (b_q == '0);
  assign prod_o        = acc_q;

endmodule
`default_nettype wire

@@ rtl/core/otsu_histogram_threshold_top.sv @@
// Top level: Otsu threshold over a 256-bin gray histogram
// Use: write pixel_format on the cfg channel (valid/ready, ready always high)
// while idle. Send pixels on the in channel (valid/stall); each beat is one
// pixel and last_pixel closes the image. A pixel beat is taken and then the
// histogram bin is updated in the next cycle; in_stall_o is high meanwhile.
// A beat that comes once the image holds MaxPixels pixels is dropped and sets
// the overflow flag. The beat marked last starts a scan of all 256 splits
// through one shared shift-add multiplier; a split with an empty class stops
// after its first product, every other split runs all 8 products. The
// threshold and overflow flag then sit in an output register until a beat
// with out_stall_i low takes them; the histogram is cleared meanwhile and
// the next image may start before the result is taken. A second result
// waits until the first has gone. After reset the block clears the
// histogram memory before taking pixels.
`default_nettype none
module otsu_histogram_threshold_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire otsu_pkg::pixel_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output otsu_pkg::result_t     out_data_o
);
  import otsu_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_INC     = 4'd2;
  localparam logic [3:0] S_SC_INIT = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_ACC  = 4'd5;
  localparam logic [3:0] S_MSTART  = 4'd6;
  localparam logic [3:0] S_MWAIT   = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  localparam logic [2:0] ST_HM    = 3'd0;
  localparam logic [2:0] ST_NS0   = 3'd1;
  localparam logic [2:0] ST_SC0   = 3'd2;
  localparam logic [2:0] ST_DEN   = 3'd3;
  localparam logic [2:0] ST_DSQ   = 3'd4;
  localparam logic [2:0] ST_LHS   = 3'd5;
  localparam logic [2:0] ST_BDSQ  = 3'd6;
  localparam logic [2:0] ST_RHS   = 3'd7;

  logic [3:0]       state_q, state_d;
  logic [2:0]       step_q;
  logic             fmt_q;
  logic [7:0]       addr_q;       // clear index and scan split
  logic [7:0]       gray_q;
  logic             last_q;
  logic [CntW-1:0]  total_q, c0_q, h_q;
  logic [SumW-1:0]  sum_q, s0_q;
  logic             ovf_q;
  logic [DiffW-1:0] p_q, d_q, bd_q;
  logic [DenW-1:0]  den_q, bden_q;
  logic [SqW-1:0]   t_q;
  logic [ProdW-1:0] lhs_q;
  logic [7:0]       best_q;
  logic             out_valid_q;
  result_t          out_data_q;

  logic [CntW-1:0]  mem [256];
  logic [CntW-1:0]  rdata_q;
  logic [7:0]       rd_addr;
  logic             mem_we;
  logic [7:0]       mem_waddr;
  logic [CntW-1:0]  mem_wdata;

  logic [12:0]      gray_sum;
  logic [7:0]       gray;
  logic             in_acc;
  logic [CntW-1:0]  c1;
  logic             mul_start;
  logic [ProdW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  mul_status_t      mul_st;
  logic [ProdW-1:0] prod;
  logic             out_take;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  assign gray_sum = 13'd11 * {5'd0, in_data_i.red} + 13'd16 * {5'd0, in_data_i.green}
                  + 13'd5 * {5'd0, in_data_i.blue_or_gray};
  assign gray     = fmt_q ? in_data_i.blue_or_gray : gray_sum[12:5];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign c1         = total_q - c0_q;

  // Histogram memory: one write port, one registered read port
  assign rd_addr = (state_q == S_IDLE) ? gray : addr_q;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_INC) begin
      mem_we    = 1'b1;
      mem_waddr = gray_q;
      mem_wdata = rdata_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      ST_HM:   begin mul_a = ProdW'(h_q);     mul_b = MulBW'(addr_q); end
      ST_NS0:  begin mul_a = ProdW'(total_q); mul_b = MulBW'(s0_q);   end
      ST_SC0:  begin mul_a = ProdW'(sum_q);   mul_b = MulBW'(c0_q);   end
      ST_DEN:  begin mul_a = ProdW'(c0_q);    mul_b = MulBW'(c1);     end
      ST_DSQ:  begin mul_a = ProdW'(d_q);     mul_b = d_q;            end
      ST_LHS:  begin mul_a = ProdW'(t_q);     mul_b = MulBW'(bden_q); end
      ST_BDSQ: begin mul_a = ProdW'(bd_q);    mul_b = bd_q;           end
      ST_RHS:  begin mul_a = ProdW'(t_q);     mul_b = MulBW'(den_q);  end
      default: begin mul_a = '0;              mul_b = '0;             end
    endcase
  end
  assign mul_start = (state_q == S_MSTART);

  otsu_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .status_o (mul_st),
    .prod_o   (prod)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (addr_q == 8'hFF) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (total_q == CntW'(MaxPixels)) begin
            state_d = in_data_i.last_pixel ? S_SC_INIT : S_IDLE;
          end else begin
            state_d = S_INC;
          end
        end
      end
      S_INC:     state_d = last_q ? S_SC_INIT : S_IDLE;
      S_SC_INIT: state_d = S_SC_RD;
      S_SC_RD:   state_d = S_SC_ACC;
      S_SC_ACC:  state_d = S_MSTART;
      S_MSTART:  state_d = S_MWAIT;
      S_MWAIT: begin
        if (mul_st.done) begin
          if (step_q == ST_HM) begin
            // skip a split with an empty class
            if ((c0_q == '0) || (c1 == '0)) begin
              state_d = (addr_q == 8'hFF) ? S_OUT : S_SC_RD;
            end else begin
              state_d = S_MSTART;
            end
          end else if (step_q == ST_RHS) begin
            state_d = (addr_q == 8'hFF) ? S_OUT : S_SC_RD;
          end else begin
            state_d = S_MSTART;
          end
        end
      end
      S_OUT:     if (!out_valid_q || !out_stall_i) state_d = S_CLEAR;
      default:   state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      step_q      <= ST_HM;
      total_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: addr_q <= addr_q + 8'd1;
        S_IDLE: begin
          if (in_acc && (total_q == CntW'(MaxPixels))) begin
            ovf_q <= 1'b1;
          end
        end
        S_INC: begin
          total_q <= total_q + CntW'(1);
          sum_q   <= sum_q + SumW'(gray_q);
        end
        S_SC_INIT: addr_q <= '0;
        S_SC_ACC:  step_q <= ST_HM;
        S_MWAIT: begin
          if (mul_st.done) begin
            if (((step_q == ST_HM) && ((c0_q == '0) || (c1 == '0)))
                || (step_q == ST_RHS)) begin
              addr_q <= addr_q + 8'd1;  // wraps to 0 after the last split
              step_q <= ST_HM;
            end else begin
              step_q <= step_q + 3'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            total_q     <= '0;
            sum_q       <= '0;
            ovf_q       <= 1'b0;
            addr_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Scan datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gray_q <= gray;
      last_q <= in_data_i.last_pixel;
    end
    case (state_q)
      S_SC_INIT: begin
        c0_q   <= '0;
        s0_q   <= '0;
        best_q <= '0;
        bd_q   <= '0;
        bden_q <= DenW'(1);
      end
      S_SC_ACC: begin
        h_q  <= rdata_q;
        c0_q <= c0_q + rdata_q;
      end
      S_MWAIT: begin
        if (mul_st.done) begin
          case (step_q)
            ST_HM:   s0_q  <= s0_q + prod[SumW-1:0];
            ST_NS0:  p_q   <= prod[DiffW-1:0];
            ST_SC0:  d_q   <= (p_q >= prod[DiffW-1:0]) ? (p_q - prod[DiffW-1:0])
                                                       : (prod[DiffW-1:0] - p_q);
            ST_DEN:  den_q <= prod[DenW-1:0];
            ST_DSQ:  t_q   <= prod[SqW-1:0];
            ST_LHS:  lhs_q <= prod;
            ST_BDSQ: t_q   <= prod[SqW-1:0];
            ST_RHS: begin
              if (lhs_q > prod) begin
                best_q <= addr_q;
                bd_q   <= d_q;
                bden_q <= den_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_q.threshold       <= (best_q == 8'd0) ? NoSplitThr : best_q;
          out_data_q.too_many_pixels <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "otsu_histogram_threshold_top_assert.svh"

  `OTSU_ASSERT_NOW(a_total_cap, 1'b1, total_q <= CntW'(MaxPixels))
  `OTSU_ASSERT_NOW(a_mul_done_waited, mul_st.done, state_q == S_MWAIT)
  `OTSU_ASSERT_NOW(a_c0_cap, (state_q == S_MSTART) || (state_q == S_MWAIT), c0_q <= total_q)
  `OTSU_ASSERT_NEXT(a_accept_leaves_idle, in_acc && (total_q != CntW'(MaxPixels)),
                    state_q == S_INC)

endmodule
`default_nettype wire

@@ sim/tb_otsu_histogram_threshold_top.sv @@
// Testbench for the Otsu threshold block: pixel images in, thresholds checked
`timescale 1ns / 100ps
`default_nettype none
module tb_otsu_histogram_threshold_top;
  import otsu_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic    cfg_data_i = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  pixel_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b1;
  result_t out_data_o;

  localparam logic FmtColour = 1'b0;
  localparam logic FmtGray   = 1'b1;

  otsu_histogram_threshold_top dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  int unsigned    bin_count [256];
  longint unsigned pix_count, gray_sum;
  bit             dropped;
  logic           fmt_model = FmtColour;
  result_t        thresholds_due [$];
  int             fail_count = 0;
  bit             long_hold = 1'b0;
  int             max_gap = 3;

  function automatic logic [7:0] gray_of(pixel_t p);
    int unsigned g;
    if (fmt_model == FmtGray) return p.blue_or_gray;
    g = (11 * p.red + 16 * p.green + 5 * p.blue_or_gray) >> 5;
    return g[7:0];
  endfunction

  // exact between-class score comparison, widths cover d^2*den
  function automatic logic [7:0] otsu_split();
    longint unsigned c0, s0, c1, d, den, p, q, bd, bden;
    logic [191:0] lhs, rhs;
    logic [7:0] best;
    c0 = 0; s0 = 0; bd = 0; bden = 1; best = 0;
    for (int m = 0; m < 256; m++) begin
      c0 += bin_count[m];
      s0 += longint'(bin_count[m]) * m;
      c1 = pix_count - c0;
      if (c0 != 0 && c1 != 0) begin
        p = pix_count * s0;
        q = gray_sum * c0;
        d = (p >= q) ? p - q : q - p;
        den = c0 * c1;
        lhs = 192'(d) * 192'(d) * 192'(bden);
        rhs = 192'(bd) * 192'(bd) * 192'(den);
        if (lhs > rhs) begin
          best = m[7:0]; bd = d; bden = den;
        end
      end
    end
    return (best == 0) ? NoSplitThr : best;
  endfunction

  function automatic void predict_pixel(pixel_t p);
    logic [7:0] g;
    result_t r;
    g = gray_of(p);
    if (pix_count >= MaxPixels) dropped = 1'b1;
    else begin
      bin_count[g]++; pix_count++; gray_sum += g;
    end
    if (p.last_pixel) begin
      r.threshold = otsu_split();
      r.too_many_pixels = dropped;
      thresholds_due.push_back(r);
      foreach (bin_count[i]) bin_count[i] = 0;
      pix_count = 0; gray_sum = 0; dropped = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, max_gap);
  endfunction

  // valid stays high into the next beat when there is no gap
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(p);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (thresholds_due.size() != 0 && guard < 1000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_format(logic f);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fmt_model = f;
  endtask

  function automatic pixel_t mk(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic l);
    pixel_t p;
    p.blue_or_gray = b; p.green = g; p.red = r; p.last_pixel = l;
    return p;
  endfunction

  task automatic send_image(int n, int lo, int hi, bit bimodal);
    int v;
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(lo, hi);
      if (bimodal && $urandom_range(0, 1)) v = 255 - v;
      if (fmt_model == FmtGray)
        send_pixel(mk(v[7:0], 8'($urandom()), 8'($urandom()), i == n - 1));
      else
        send_pixel(mk(8'($urandom_range(lo, hi)), 8'(bimodal && i[0] ? 255 - v : v),
                      8'($urandom_range(lo, hi)), i == n - 1));
    end
  endtask

  task automatic test_directed();
    set_format(FmtGray);
    send_pixel(mk(8'd0, 8'hff, 8'hff, 1'b1));            // single pixel: no split
    send_pixel(mk(8'd77, 8'h00, 8'h00, 1'b0));           // uniform image
    send_pixel(mk(8'd77, 8'h00, 8'h00, 1'b1));
    send_pixel(mk(8'd0, 8'h00, 8'h00, 1'b0));            // two extremes: split at 0
    send_pixel(mk(8'd255, 8'h00, 8'h00, 1'b1));
    send_pixel(mk(8'd10, 8'h00, 8'h00, 1'b0));           // tie candidates
    send_pixel(mk(8'd20, 8'h00, 8'h00, 1'b0));
    send_pixel(mk(8'd30, 8'h00, 8'h00, 1'b1));
    wait_drained();
    set_format(FmtColour);
    send_pixel(mk(8'hff, 8'hff, 8'hff, 1'b0));
    send_pixel(mk(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(mk(8'hff, 8'h00, 8'h00, 1'b0));
    send_pixel(mk(8'h00, 8'hff, 8'h00, 1'b0));
    send_pixel(mk(8'h00, 8'h00, 8'hff, 1'b0));
    send_pixel(mk(8'haa, 8'h55, 8'haa, 1'b0));
    send_pixel(mk(8'h55, 8'haa, 8'h55, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_gray();
    set_format(FmtGray);
    for (int k = 0; k < 50; k++)
      send_image($urandom_range(2, 16), $urandom_range(0, 100), $urandom_range(120, 255),
                 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  task automatic test_random_colour();
    set_format(FmtColour);
    for (int k = 0; k < 50; k++)
      send_image($urandom_range(1, 16), 0, 255, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // hold the result port for a long stretch while images keep arriving
  task automatic test_backpressure();
    set_format(FmtGray);
    long_hold = 1'b1;
    for (int k = 0; k < 8; k++) send_image($urandom_range(3, 10), 0, 255, 1'b1);
    long_hold = 1'b0;
    max_gap = 0;
    for (int k = 0; k < 10; k++) send_image($urandom_range(2, 12), 0, 255, 1'b0);
    max_gap = 3;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_gray();
    test_random_colour();
    test_backpressure();
    set_format(FmtColour);
    wait_drained();
    if (fail_count == 0) $display("tb_otsu_histogram_threshold_top: done, clean");
    else $display("tb_otsu_histogram_threshold_top: done, errors");
    $finish;
  end

  // result port stalls, counted in cycles
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (60000) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // compare each accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (thresholds_due.size() == 0) begin
        $error("unexpected result beat %p", out_data_o);
        fail_count++;
      end else begin
        want = thresholds_due.pop_front();
        if (out_data_o.threshold !== want.threshold) begin
          $error("threshold: expected %0d, got %0d", want.threshold, out_data_o.threshold);
          fail_count++;
        end
        if (out_data_o.too_many_pixels !== want.too_many_pixels) begin
          $error("too_many_pixels: expected %0b, got %0b", want.too_many_pixels,
                 out_data_o.too_many_pixels);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("tb_otsu_histogram_threshold_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/otsu_pkg.sv
rtl/core/otsu_mul.sv
rtl/core/otsu_histogram_threshold_top.sv
sim/tb_otsu_histogram_threshold_top.sv
